// File: rtl/qfa_pkg.sv
// Package for the Q32.32 fixed-point ALU.
// Holds the operation codes, the beat payload structs and the pipeline tag type.
// Depends on nothing.
package qfa_pkg;

   // Operation codes carried in the operation field.
   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MUL_INT  = 4'd4,
      OP_DIV_INT  = 4'd5,
      OP_ABS      = 4'd6,
      OP_FROM_INT = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_ADD_INT  = 4'd9,
      OP_SUB_INT  = 4'd10
   } op_type;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = 32;

   // Request beat.
   typedef struct packed {
      logic [3:0]               operation;
      logic signed [WORD_W-1:0] operand_a;
      logic signed [WORD_W-1:0] operand_b;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic signed [WORD_W-1:0] result;
      logic                     divide_by_zero;
   } rsp_type;

   // Per-item tag that travels down the pipeline next to the data.
   typedef struct packed {
      logic              is_mul;
      logic              is_div;
      logic              neg;
      logic              dz;
      logic [WORD_W-1:0] res;
   } tag_type;

endpackage

// File: rtl/q32_32_fixed_point_alu.sv
// Q32.32 fixed-point ALU, top level: decode, split multiplier and bit-per-stage divider.
// Depends on qfa_pkg for the payload structs, the operation codes and the tag type.
//
// Every beat takes the same path through every register stage:
// the divider is a restoring divider with one quotient bit per register stage over a
// dividend of 64 + FRAC_BITS bits, and every operation flows through it so results come
// out in order. A new beat is taken every cycle; the whole pipeline holds while a
// finished response waits at the output register.
module q32_32_fixed_point_alu
   import qfa_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned HALF_SHIFT = FRAC_BITS / 2;
   localparam int unsigned DVD_W      = WORD_W + FRAC_BITS;
   localparam int unsigned NSTEP      = DVD_W;

   // Global advance: the pipeline moves unless a response is stuck at the output.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------------------------------------------------------- stage 0
   logic [WORD_W-1:0] a_in, b_in, n_in, ma_in, mb_in, mn_in;
   logic [WORD_W-1:0] asr_a_in, asr_b_in, toint_in;
   tag_type           tag0_in;
   logic [WORD_W-1:0] mx0_in, my0_in, dvs0_in;
   logic [DVD_W-1:0]  dvd0_in;

   assign a_in     = req_data.operand_a;
   assign b_in     = req_data.operand_b;
   assign n_in     = {{HALF_W{b_in[HALF_W-1]}}, b_in[HALF_W-1:0]};
   assign ma_in    = a_in[WORD_W-1] ? (~a_in + 1'b1) : a_in;
   assign mb_in    = b_in[WORD_W-1] ? (~b_in + 1'b1) : b_in;
   assign mn_in    = n_in[WORD_W-1] ? (~n_in + 1'b1) : n_in;
   assign asr_a_in = WORD_W'($signed(a_in) >>> HALF_SHIFT);
   assign asr_b_in = WORD_W'($signed(b_in) >>> HALF_SHIFT);
   assign toint_in = WORD_W'($signed(a_in) >>> FRAC_BITS);

   // Decode the operation and work out the results that need neither multiplier nor divider.
   always_comb begin
      tag0_in = '0;
      mx0_in  = a_in;
      my0_in  = n_in;
      dvd0_in = {{FRAC_BITS{1'b0}}, ma_in};
      dvs0_in = mn_in;
      unique case (req_data.operation)
         OP_ADD:      tag0_in.res = a_in + b_in;
         OP_SUB:      tag0_in.res = a_in - b_in;
         OP_MUL: begin
            tag0_in.is_mul = 1'b1;
            mx0_in = asr_a_in;
            my0_in = asr_b_in;
         end
         OP_DIV: begin
            tag0_in.is_div = 1'b1;
            tag0_in.dz     = (b_in == '0);
            tag0_in.neg    = a_in[WORD_W-1] ^ b_in[WORD_W-1];
            dvd0_in        = {ma_in, {FRAC_BITS{1'b0}}};
            dvs0_in        = mb_in;
         end
         OP_MUL_INT:  tag0_in.is_mul = 1'b1;
         OP_DIV_INT: begin
            tag0_in.is_div = 1'b1;
            tag0_in.dz     = (b_in[HALF_W-1:0] == '0);
            tag0_in.neg    = a_in[WORD_W-1] ^ b_in[HALF_W-1];
         end
         OP_ABS:      tag0_in.res = ma_in;
         OP_FROM_INT: tag0_in.res = n_in << FRAC_BITS;
         OP_TO_INT:   tag0_in.res = {{HALF_W{toint_in[HALF_W-1]}}, toint_in[HALF_W-1:0]};
         OP_ADD_INT:  tag0_in.res = a_in + (n_in << FRAC_BITS);
         OP_SUB_INT:  tag0_in.res = a_in - (n_in << FRAC_BITS);
         default:     tag0_in.res = '0;
      endcase
   end

   logic              v0_ff;
   tag_type           tag0_ff;
   logic [WORD_W-1:0] mx0_ff, my0_ff, dvs0_ff;
   logic [DVD_W-1:0]  dvd0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag0_ff <= tag0_in;
         mx0_ff  <= mx0_in;
         my0_ff  <= my0_in;
         dvd0_ff <= dvd0_in;
         dvs0_ff <= dvs0_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Three 32x32 partial products; the high-by-high term falls off the low word.
   logic [WORD_W-1:0] pp_ll_in;
   logic [HALF_W-1:0] pp_lh_in, pp_hl_in;

   assign pp_ll_in = WORD_W'(mx0_ff[HALF_W-1:0]) * WORD_W'(my0_ff[HALF_W-1:0]);
   assign pp_lh_in = mx0_ff[HALF_W-1:0] * my0_ff[WORD_W-1:HALF_W];
   assign pp_hl_in = mx0_ff[WORD_W-1:HALF_W] * my0_ff[HALF_W-1:0];

   logic              v1_ff;
   tag_type           tag1_ff;
   logic [WORD_W-1:0] pp_ll1_ff, dvs1_ff;
   logic [HALF_W-1:0] pp_lh1_ff, pp_hl1_ff;
   logic [DVD_W-1:0]  dvd1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag1_ff   <= tag0_ff;
         pp_ll1_ff <= pp_ll_in;
         pp_lh1_ff <= pp_lh_in;
         pp_hl1_ff <= pp_hl_in;
         dvd1_ff   <= dvd0_ff;
         dvs1_ff   <= dvs0_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Sum the partial products and load the first divider stage.
   tag_type           tag2_in;
   logic [HALF_W-1:0] cross_in;

   assign cross_in = pp_lh1_ff + pp_hl1_ff;

   always_comb begin
      tag2_in = tag1_ff;
      if (tag1_ff.is_mul) begin
         tag2_in.res = pp_ll1_ff + {cross_in, {HALF_W{1'b0}}};
      end
   end

   logic              vld_ff [NSTEP+1];
   tag_type           tag_ff [NSTEP+1];
   logic [WORD_W-1:0] rem_ff [NSTEP+1];
   logic [WORD_W-1:0] quo_ff [NSTEP+1];
   logic [WORD_W-1:0] dvs_ff [NSTEP+1];
   logic [DVD_W-1:0]  dvd_ff [NSTEP+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= tag2_in;
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
         dvs_ff[0] <= dvs1_ff;
         dvd_ff[0] <= dvd1_ff;
      end
   end

   // ---------------------------------------------------------------- divider
   // One restoring step per stage: shift in the next dividend bit, try to subtract.
   for (genvar k = 1; k <= NSTEP; k++) begin : g_div
      logic [WORD_W:0]   trial_in;
      logic [WORD_W:0]   diff_in;
      logic              take_in;

      assign trial_in = {rem_ff[k-1], dvd_ff[k-1][DVD_W-1]};
      assign diff_in  = trial_in - {1'b0, dvs_ff[k-1]};
      assign take_in  = !diff_in[WORD_W];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[k] <= tag_ff[k-1];
            rem_ff[k] <= take_in ? diff_in[WORD_W-1:0] : trial_in[WORD_W-1:0];
            quo_ff[k] <= {quo_ff[k-1][WORD_W-2:0], take_in};
            dvs_ff[k] <= dvs_ff[k-1];
            dvd_ff[k] <= {dvd_ff[k-1][DVD_W-2:0], 1'b0};
         end
      end
   end

   // ---------------------------------------------------------------- output
   // Apply the quotient sign, force zero on a zero divisor, and register the beat.
   rsp_type rsp_in;
   tag_type last_tag;
   logic [WORD_W-1:0] q_last;

   assign last_tag = tag_ff[NSTEP];
   assign q_last   = quo_ff[NSTEP];

   always_comb begin
      rsp_in.divide_by_zero = last_tag.dz;
      priority if (last_tag.dz) begin
         rsp_in.result = '0;
      end else if (last_tag.is_div) begin
         rsp_in.result = last_tag.neg ? (~q_last + 1'b1) : q_last;
      end else begin
         rsp_in.result = last_tag.res;
      end
   end

   logic    out_v_ff;
   rsp_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= vld_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTH
   // A zero divisor always reports a zero result.
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_by_zero |-> rsp_data.result == '0)
      else $error("divide_by_zero set with nonzero result");

   // Only divide operations can raise the zero-divisor flag.
   a_dz_div: assert property (@(posedge clock) disable iff (reset)
      v0_ff && tag0_ff.dz |-> tag0_ff.is_div)
      else $error("zero-divisor flag on a non-divide operation");

   // An accepted beat lands in the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v0_ff)
      else $error("accepted beat missing from stage 0");

   // While stalled, the last divider stage holds its beat.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff[NSTEP]) && $stable(quo_ff[NSTEP]))
      else $error("divider output moved during a stall");
`endif

endmodule
